### sv/spp_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool package
// Shared widths, operation and status codes and the slot index mapping.
// ----------------------------------------------------------------------------
package spp_pkg;

    // Number of link entries held in each link store.
    localparam int SLOTS = 256;

    // Fixed widths of the beat fields and of the limit register.
    localparam int SLOT_W   = 8;
    localparam int LIMIT_W  = 9;
    localparam int ADDR_W   = $clog2(SLOTS);

    // The limit in force never exceeds the store depth nor the slot field range.
    localparam int LIMIT_CAP = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [1:0]         op_t;
    typedef logic [1:0]         status_t;

    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_FREE   = 2'd1;
    localparam op_t OP_UNLINK = 2'd2;
    localparam op_t OP_READ   = 2'd3;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_HEAD = 2'd2;

    localparam limit_t SLOT_LIMIT_RESET = limit_t'(256);

    // Maps a slot number onto a store address; slots beyond the store fold to the head.
    function automatic addr_t ix(input slot_t i);
        addr_t a;
        a = '0;
        if (32'(i) < SLOTS)
        begin
            a = addr_t'(i);
        end
        return a;
    endfunction

endpackage

### sv/spp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/slot_pool_with_linked_list.sv
// ----------------------------------------------------------------------------
// Slot pool with linked list
// Free list allocator with a circular doubly linked active list headed by slot 0.
// ----------------------------------------------------------------------------
// From the accepted input beat, refused, ignored or head reads go straight to the
// done state; reads and unlinks pass the read state, adds and frees the read and second write states.
// One item is in flight at a time; a new beat is taken the cycle after the result
// is loaded, which waits while a stalled result holds the output register. The second write
// state serves the two writes that an add or a free makes into the same link RAM. Reset clears
// the control state and the head links at once; the link RAMs are not cleared and need no clearing pass.
module slot_pool_with_linked_list (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  spp_pkg::limit_t       cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  spp_pkg::op_t          operation,
    input  spp_pkg::slot_t        slot,
    output logic                  out_valid,
    input  logic                  out_stall,
    output spp_pkg::slot_t        slot_out,
    output spp_pkg::status_t      status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_W2   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [2:0] P_NONE     = 3'd0;
    localparam logic [2:0] P_ADD_FREE = 3'd1;
    localparam logic [2:0] P_ADD_BUMP = 3'd2;
    localparam logic [2:0] P_READ     = 3'd3;
    localparam logic [2:0] P_UNLINK   = 3'd4;
    localparam logic [2:0] P_FREE     = 3'd5;

    logic [1:0]         state_reg, state_next;
    logic [2:0]         plan_reg, plan_next;
    spp_pkg::slot_t     item_slot_reg, item_slot_next;
    spp_pkg::slot_t     res_reg, res_next;
    spp_pkg::status_t   sts_reg, sts_next;
    spp_pkg::slot_t     out_slot_reg, out_slot_next;
    spp_pkg::status_t   out_status_reg, out_status_next;
    logic               out_valid_reg, out_valid_next;
    spp_pkg::limit_t    slot_limit_reg, slot_limit_next;
    spp_pkg::limit_t    bump_mark_reg, bump_mark_next;
    spp_pkg::slot_t     free_top_reg, free_top_next;
    logic               free_nonempty_reg, free_nonempty_next;
    spp_pkg::slot_t     head_fwd_reg, head_fwd_next;
    spp_pkg::slot_t     head_bwd_reg, head_bwd_next;

    logic               fwd_we, bwd_we;
    spp_pkg::addr_t     fwd_waddr, bwd_waddr, fwd_raddr, bwd_raddr;
    spp_pkg::slot_t     fwd_wdata, bwd_wdata, fwd_rdata, bwd_rdata;
    spp_pkg::limit_t    limit_now;
    logic               in_use;

    // Entry 0 of each link store lives in the head registers; the RAMs hold the rest.
    spp_ram #(.WIDTH(spp_pkg::SLOT_W), .DEPTH(spp_pkg::SLOTS)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    spp_ram #(.WIDTH(spp_pkg::SLOT_W), .DEPTH(spp_pkg::SLOTS)) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .raddr (bwd_raddr),
        .rdata (bwd_rdata)
    );

    assign limit_now = (slot_limit_reg > spp_pkg::limit_t'(spp_pkg::LIMIT_CAP))
                     ? spp_pkg::limit_t'(spp_pkg::LIMIT_CAP) : slot_limit_reg;
    assign in_use    = ({1'b0, slot} < bump_mark_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign fwd_raddr = (operation == spp_pkg::OP_ADD) ? spp_pkg::ix(free_top_reg)
                                                       : spp_pkg::ix(slot);
    assign bwd_raddr = spp_pkg::ix(slot);

    always_comb
    begin
        state_next         = state_reg;
        plan_next          = plan_reg;
        item_slot_next     = item_slot_reg;
        res_next           = res_reg;
        sts_next           = sts_reg;
        out_slot_next      = out_slot_reg;
        out_status_next    = out_status_reg;
        out_valid_next     = out_valid_reg && out_stall;
        slot_limit_next    = cfg_we ? cfg_data : slot_limit_reg;
        bump_mark_next     = bump_mark_reg;
        free_top_next      = free_top_reg;
        free_nonempty_next = free_nonempty_reg;
        head_fwd_next      = head_fwd_reg;
        head_bwd_next      = head_bwd_reg;
        fwd_we             = 1'b0;
        fwd_waddr          = '0;
        fwd_wdata          = '0;
        bwd_we             = 1'b0;
        bwd_waddr          = '0;
        bwd_wdata          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_slot_next = slot;
                    res_next       = '0;
                    sts_next       = spp_pkg::ST_OK;
                    plan_next      = P_NONE;
                    state_next     = S_DONE;
                    case (operation)
                        spp_pkg::OP_ADD:
                        begin
                            if (free_nonempty_reg)
                            begin
                                plan_next      = P_ADD_FREE;
                                item_slot_next = free_top_reg;
                                state_next     = S_RD;
                            end
                            else if (bump_mark_reg < limit_now)
                            begin
                                plan_next      = P_ADD_BUMP;
                                item_slot_next = bump_mark_reg[spp_pkg::SLOT_W-1:0];
                                bump_mark_next = bump_mark_reg + spp_pkg::limit_t'(1);
                                state_next     = S_RD;
                            end
                            else
                            begin
                                sts_next = spp_pkg::ST_FULL;
                            end
                        end
                        spp_pkg::OP_READ:
                        begin
                            if (in_use)
                            begin
                                if (spp_pkg::ix(slot) == '0)
                                begin
                                    res_next = head_fwd_reg;
                                end
                                else
                                begin
                                    plan_next  = P_READ;
                                    state_next = S_RD;
                                end
                            end
                        end
                        default:
                        begin
                            if (slot == '0)
                            begin
                                sts_next = spp_pkg::ST_HEAD;
                            end
                            else if (in_use)
                            begin
                                plan_next  = (operation == spp_pkg::OP_FREE) ? P_FREE : P_UNLINK;
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_DONE;
                case (plan_reg)
                    P_ADD_FREE, P_ADD_BUMP:
                    begin
                        if (plan_reg == P_ADD_FREE)
                        begin
                            free_top_next      = fwd_rdata;
                            free_nonempty_next = (fwd_rdata != '0);
                        end
                        // New slot points forward at the old first slot, which points back.
                        fwd_we    = 1'b1;
                        fwd_waddr = spp_pkg::ix(item_slot_reg);
                        fwd_wdata = head_fwd_reg;
                        if (spp_pkg::ix(head_fwd_reg) == '0)
                        begin
                            head_bwd_next = item_slot_reg;
                        end
                        else
                        begin
                            bwd_we    = 1'b1;
                            bwd_waddr = spp_pkg::ix(head_fwd_reg);
                            bwd_wdata = item_slot_reg;
                        end
                        res_next   = item_slot_reg;
                        state_next = S_W2;
                    end
                    P_READ:
                    begin
                        res_next = fwd_rdata;
                    end
                    P_UNLINK, P_FREE:
                    begin
                        if (spp_pkg::ix(fwd_rdata) == '0)
                        begin
                            head_bwd_next = bwd_rdata;
                        end
                        else
                        begin
                            bwd_we    = 1'b1;
                            bwd_waddr = spp_pkg::ix(fwd_rdata);
                            bwd_wdata = bwd_rdata;
                        end
                        if (spp_pkg::ix(bwd_rdata) == '0)
                        begin
                            head_fwd_next = fwd_rdata;
                        end
                        else
                        begin
                            fwd_we    = 1'b1;
                            fwd_waddr = spp_pkg::ix(bwd_rdata);
                            fwd_wdata = fwd_rdata;
                        end
                        if (plan_reg == P_FREE)
                        begin
                            state_next = S_W2;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_W2:
            begin
                state_next = S_DONE;
                if (plan_reg == P_FREE)
                begin
                    // Push the freed slot; its forward link chains the free list.
                    fwd_we             = 1'b1;
                    fwd_waddr          = spp_pkg::ix(item_slot_reg);
                    fwd_wdata          = free_nonempty_reg ? free_top_reg : '0;
                    free_top_next      = item_slot_reg;
                    free_nonempty_next = 1'b1;
                end
                else
                begin
                    bwd_we        = 1'b1;
                    bwd_waddr     = spp_pkg::ix(item_slot_reg);
                    bwd_wdata     = '0;
                    head_fwd_next = item_slot_reg;
                end
            end

            S_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = res_reg;
                    out_status_next = sts_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            plan_reg          <= P_NONE;
            out_valid_reg     <= 1'b0;
            slot_limit_reg    <= spp_pkg::SLOT_LIMIT_RESET;
            bump_mark_reg     <= spp_pkg::limit_t'(1);
            free_top_reg      <= '0;
            free_nonempty_reg <= 1'b0;
            head_fwd_reg      <= '0;
            head_bwd_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            plan_reg          <= plan_next;
            out_valid_reg     <= out_valid_next;
            slot_limit_reg    <= slot_limit_next;
            bump_mark_reg     <= bump_mark_next;
            free_top_reg      <= free_top_next;
            free_nonempty_reg <= free_nonempty_next;
            head_fwd_reg      <= head_fwd_next;
            head_bwd_reg      <= head_bwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_slot_reg  <= item_slot_next;
        res_reg        <= res_next;
        sts_reg        <= sts_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign slot_out  = out_slot_reg;
    assign status    = out_status_reg;

    // A non-empty free list never has the head slot on top.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_nonempty_reg |-> (free_top_reg != '0))
        else $error("free list top is the head slot");

    // The bump mark stays between the first usable slot and the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bump_mark_reg != '0) && (32'(bump_mark_reg) <= spp_pkg::SLOTS))
        else $error("bump mark out of range");

    // Entry 0 is held in registers, so neither RAM is ever written there.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_we |-> (fwd_waddr != '0)) and (bwd_we |-> (bwd_waddr != '0)))
        else $error("link RAM write to the head entry");

    // A finished item is presented as soon as the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !(out_valid_reg && out_stall)) |=>
            (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not loaded into the output register");

    // Only the bump path of an add moves the bump mark, and by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bump_mark_reg != $past(bump_mark_reg)) |->
            (bump_mark_reg == $past(bump_mark_reg) + spp_pkg::limit_t'(1)))
        else $error("bump mark moved by other than one");

endmodule

### sim/slot_pool_with_linked_list_tb.sv
// ----------------------------------------------------------------------------
// Slot pool with linked list testbench
// Runs a table of directed beats, then random phases at several slot limits
// and idling mixes. Every result beat is checked against a directed answer or a local model of the
// link stores, free list and bump mark, kept in step with accepted beats.
// ----------------------------------------------------------------------------
module slot_pool_with_linked_list_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spp_pkg::*;

    typedef struct packed {
        slot_t   slot_out;
        status_t status;
    } pool_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        op_t       op;
        slot_t     slot;
        limit_t    lim;
        logic      typed;
        slot_t     exp_slot;
        status_t   exp_status;
    } plan_row_t;

    // Directed beats. Rows with typed set carry an answer that is plain from the
    // state at that point; the rest are checked against the pool model.
    localparam int PLAN_ROWS = 27;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_ITEM, OP_READ,   8'd0,   9'd0,   1'b1, 8'd0, ST_OK},
        '{ROW_ITEM, OP_FREE,   8'd0,   9'd0,   1'b1, 8'd0, ST_HEAD},
        '{ROW_ITEM, OP_UNLINK, 8'd0,   9'd0,   1'b1, 8'd0, ST_HEAD},
        '{ROW_ITEM, OP_FREE,   8'd255, 9'd0,   1'b1, 8'd0, ST_OK},
        '{ROW_ITEM, OP_UNLINK, 8'd1,   9'd0,   1'b1, 8'd0, ST_OK},
        '{ROW_ITEM, OP_READ,   8'd255, 9'd0,   1'b1, 8'd0, ST_OK},
        '{ROW_CFG,  OP_ADD,    8'd0,   9'd2,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd0,   9'd0,   1'b1, 8'd1, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd255, 9'd0,   1'b1, 8'd0, ST_FULL},
        '{ROW_ITEM, OP_READ,   8'd0,   9'd0,   1'b1, 8'd1, ST_OK},
        '{ROW_ITEM, OP_READ,   8'd1,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_FREE,   8'd1,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd0,   9'd0,   1'b1, 8'd1, ST_OK},
        '{ROW_ITEM, OP_UNLINK, 8'd1,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_READ,   8'd0,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_FREE,   8'd1,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_FREE,   8'd1,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd0,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd0,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_CFG,  OP_ADD,    8'd0,   9'd256, 1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd0,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd0,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd0,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_UNLINK, 8'd2,   9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_READ,   8'd255, 9'd0,   1'b1, 8'd0, ST_OK},
        '{ROW_ITEM, OP_ADD,    8'd255, 9'd0,   1'b0, 8'd0, ST_OK},
        '{ROW_ITEM, OP_READ,   8'd0,   9'd0,   1'b0, 8'd0, ST_OK}
    };

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    cfg_we    = 1'b0;
    limit_t  cfg_data  = '0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    op_t     operation = OP_ADD;
    slot_t   slot      = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    slot_t   slot_out;
    status_t status;

    // Pool model state.
    slot_t        next_of [SLOTS];
    slot_t        prev_of [SLOTS];
    logic [8:0]   high_water;
    slot_t        spare_top;
    logic         spare_any;
    limit_t       limit_reg;

    pool_result_t expected_q [$];
    slot_t        live_q [$];
    int           mismatches = 0;
    int           idle_pct   = 0;
    int           stall_pct  = 0;
    int           hold_ask   = 0;

    slot_pool_with_linked_list uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .slot      (slot),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .slot_out  (slot_out),
        .status    (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int limit_in_force();
        return (int'(limit_reg) > LIMIT_CAP) ? LIMIT_CAP : int'(limit_reg);
    endfunction

    // Applies one beat to the pool model and returns the answer it should give.
    function automatic pool_result_t pool_step(op_t op, slot_t s);
        pool_result_t r;
        slot_t        got;
        slot_t        n;
        slot_t        p;
        logic         ok;
        r.slot_out = '0;
        r.status   = ST_OK;
        case (op)
            OP_ADD:
            begin
                ok = 1'b1;
                got = '0;
                if (spare_any)
                begin
                    got = spare_top;
                    spare_top = next_of[got];
                    spare_any = (spare_top != 0);
                end
                else if (int'(high_water) < limit_in_force())
                begin
                    got = high_water[7:0];
                    high_water = high_water + 9'd1;
                end
                else
                begin
                    ok = 1'b0;
                    r.status = ST_FULL;
                end
                if (ok)
                begin
                    n = next_of[0];
                    next_of[got] = n;
                    prev_of[n] = got;
                    prev_of[got] = '0;
                    next_of[0] = got;
                    r.slot_out = got;
                end
            end
            OP_READ:
            begin
                if (9'(s) < high_water)
                begin
                    r.slot_out = next_of[s];
                end
            end
            default:
            begin
                if (s == 0)
                begin
                    r.status = ST_HEAD;
                end
                else if (9'(s) < high_water)
                begin
                    n = next_of[s];
                    p = prev_of[s];
                    prev_of[n] = p;
                    next_of[p] = n;
                    if (op == OP_FREE)
                    begin
                        next_of[s] = spare_any ? spare_top : '0;
                        spare_top = s;
                        spare_any = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Keeps a list of slots believed to be on the active list, for well-formed stimulus.
    function automatic void track_live(op_t op, slot_t s, pool_result_t r);
        if (op == OP_ADD && r.status == ST_OK)
        begin
            live_q.push_back(r.slot_out);
        end
        else if (op == OP_FREE || op == OP_UNLINK)
        begin
            for (int i = live_q.size() - 1; i >= 0; i--)
            begin
                if (live_q[i] == s)
                begin
                    live_q.delete(i);
                end
            end
        end
    endfunction

    function automatic slot_t pick_slot(int live_pct);
        if (live_q.size() != 0 && $urandom_range(99) < live_pct)
        begin
            return live_q[$urandom_range(live_q.size() - 1)];
        end
        return slot_t'($urandom_range(255));
    endfunction

    task automatic check_result();
        pool_result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result beat, slot_out %0d status %0d",
                     $time, slot_out, status);
            mismatches++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (slot_out !== want.slot_out)
            begin
                $display("%0t: slot_out mismatch, expected %0d, actual %0d",
                         $time, want.slot_out, slot_out);
                mismatches++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                mismatches++;
            end
        end
    endtask

    // Result side: checks accepted beats and drives out_stall. A long hold-off
    // is started when the stimulus side bumps hold_ask.
    initial
    begin : result_side
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                check_result();
            end
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic offer(op_t op, slot_t s, logic typed, pool_result_t given);
        pool_result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        slot      <= s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        r = pool_step(op, s);
        expected_q.push_back(typed ? given : r);
        track_live(op, s, r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_limit(limit_t lim);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_reg = lim;
    endtask

    // Mostly well-formed beats on live slots, with some noise on random slots.
    task automatic random_beat(int add_pct);
        op_t   op;
        slot_t s;
        int    r;
        r = $urandom_range(99);
        s = slot_t'($urandom_range(255));
        if (r < add_pct)
        begin
            op = OP_ADD;
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                op = OP_FREE;
                s = pick_slot(90);
            end
            else if (r < 60)
            begin
                op = OP_UNLINK;
                s = pick_slot(90);
            end
            else
            begin
                op = OP_READ;
                s = ($urandom_range(9) < 2) ? slot_t'(0) : pick_slot(60);
            end
        end
        offer(op, s, 1'b0, '0);
    endtask

    task automatic run_phase(limit_t lim, int beats, int add_pct, int send_pct, int recv_pct);
        write_limit(lim);
        idle_pct  = send_pct;
        stall_pct = recv_pct;
        for (int k = 0; k < beats; k++)
        begin
            // The sender pauses halfway until every result is back.
            if (k == beats / 2)
            begin
                drain();
            end
            random_beat(add_pct);
        end
    endtask

    initial
    begin : stimulus
        pool_result_t given;
        for (int i = 0; i < SLOTS; i++)
        begin
            next_of[i] = '0;
            prev_of[i] = '0;
        end
        high_water = 9'd1;
        spare_top  = '0;
        spare_any  = 1'b0;
        limit_reg  = SLOT_LIMIT_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                write_limit(PLAN[i].lim);
            end
            else
            begin
                given.slot_out = PLAN[i].exp_slot;
                given.status   = PLAN[i].exp_status;
                offer(PLAN[i].op, PLAN[i].slot, PLAN[i].typed, given);
            end
        end

        run_phase(9'd8,   150, 40, 0,  0);
        run_phase(9'd8,   150, 40, 45, 0);
        run_phase(9'd64,  150, 45, 0,  45);

        // Long hold-off on the result side while beats keep coming, so that the
        // block fills and stalls its input.
        drain();
        idle_pct  = 0;
        stall_pct = 0;
        hold_ask++;
        for (int k = 0; k < 30; k++)
        begin
            random_beat(50);
        end

        // Add-heavy phases at the full limit drive the pool to full.
        run_phase(9'd256, 300, 80, 12, 12);
        run_phase(9'd256, 200, 80, 0,  0);
        // Limit lowered below the bump mark: adds only reuse freed slots.
        run_phase(9'd2,   150, 45, 0,  45);
        run_phase(9'd129, 150, 45, 12, 12);

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
